### rtl/best_fit_free_list_allocator_core_macros.svh
// Assertion macros for the allocator checker.
// The module that uses them has ports named clock and reset.
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Clocked property, masked while reset is high.
`define BFLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define BFLA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/bfla_pkg.sv
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared types and constants of the best-fit free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bfla_pkg;
   localparam int DESCRIPTORS_DEF = 256;
   localparam logic [20:0] BASE_RESET  = 21'd20496;
   localparam logic [20:0] LIMIT_RESET = 21'd1867711;

   localparam logic [1:0] MODE_ALLOC    = 2'd0;
   localparam logic [1:0] MODE_FREE     = 2'd1;
   localparam logic [1:0] MODE_FREE_ALL = 2'd2;

   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_SIZE = 3'd1,
      ST_NO_ROOM   = 3'd2,
      ST_NO_DESC   = 3'd3,
      ST_FREE_IGN  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_FREE_RD,
      S_FREE_SIZE,
      S_ROOM,
      S_SCAN,
      S_PLACE,
      S_LINK,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

### rtl/best_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_core
// Best-fit allocator over a size-sorted free list with a descriptor table.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  req     | req_valid / req_ready  | req_mode, req_request_size, req_handle_in
//  rsp     | rsp_valid / rsp_ready  | rsp_handle_out, rsp_status
//  csr     | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
//  One word in flight; req_ready is high only in idle. A finished word waits in
//  done while the output register still holds a word not yet taken.
//  Reset clears used flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module best_fit_free_list_allocator_core #(
   parameter int DESCRIPTORS = bfla_pkg::DESCRIPTORS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [20:0] req_request_size,
   input  wire logic [31:0] req_handle_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_handle_out,
   output logic [2:0]       rsp_status,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import bfla_pkg::*;

   localparam int IW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
   localparam logic [IW-1:0] LAST = IW'(DESCRIPTORS - 1);

   // descriptor table: {address, size} and {listed, next link}
   logic [41:0]   sa_mem [DESCRIPTORS];
   logic [IW:0]   nx_mem [DESCRIPTORS];

   state_type state_ff, state_in;
   logic             op_free_ff, op_free_in;
   logic [21:0]      want_ff, want_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [IW-1:0]    prev_ff, prev_in;
   logic [IW-1:0]    fidx_ff, fidx_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    at_ff, at_in;
   logic [IW-1:0]    scan_ff, scan_in;
   logic [31:0]      res_handle_ff, res_handle_in;
   status_type       res_status_ff, res_status_in;
   logic [DESCRIPTORS-1:0] used_ff, used_in;
   logic             head_valid_ff, head_valid_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [20:0]      end_ff, end_in;
   logic [20:0]      base_ff, limit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_handle_ff;
   logic [2:0]       rsp_status_ff;
   logic [41:0]      rd_sa_ff;
   logic [IW:0]      rd_nx_ff;

   logic             sa_we, nx_we;
   logic [IW-1:0]    sa_waddr, nx_waddr;
   logic [IW:0]      nx_wdata;
   logic [41:0]      sa_wdata;
   logic             rsp_load;

   logic [20:0]   rd_addr, rd_size, room, carve_addr;
   logic [IW-1:0] rd_next;
   logic          rd_listed;
   logic [7:0]    hin_id;
   logic          id_bad;

   assign rd_addr    = rd_sa_ff[41:21];
   assign rd_size    = rd_sa_ff[20:0];
   assign rd_next    = rd_nx_ff[IW-1:0];
   assign rd_listed  = rd_nx_ff[IW];
   assign room       = (limit_ff >= end_ff) ? (limit_ff - end_ff) : 21'd0;
   assign carve_addr = {end_ff[20:7], 7'd0} + 21'd128;
   assign hin_id     = req_handle_in[31:24];
   assign id_bad     = ({1'b0, hin_id} >= 9'(DESCRIPTORS));

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;
   assign pready         = 1'b1;
   assign prdata         = {11'd0, (paddr[2] == REG_LIMIT) ? limit_ff : base_ff};
   assign rsp_load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_ALLOC && req_request_size != 21'd0) begin
                  state_in = head_valid_ff ? S_WALK_RD : S_ROOM;
               end else if (req_mode == MODE_FREE && !(req_handle_in == 32'd0 || id_bad
                            || !used_ff[hin_id[IW-1:0]])) begin
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FREE_RD:   state_in = S_FREE_SIZE;
         S_FREE_SIZE: state_in = rd_listed ? S_DONE : (head_valid_ff ? S_WALK_RD : S_PLACE);
         S_WALK_RD:   state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            if ({1'b0, rd_size} >= want_ff) begin
               state_in = op_free_ff ? S_PLACE : S_LINK;
            end else if (rd_next == cur_ff) begin
               state_in = op_free_ff ? S_PLACE : S_ROOM;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_ROOM: begin
            if ({1'b0, want_ff} + 23'd128 > {2'b0, room}) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!used_ff[scan_ff] || scan_ff == LAST) begin
               state_in = S_DONE;
            end
         end
         S_PLACE: state_in = S_LINK;
         S_LINK:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory write control
   always_comb begin
      op_free_in    = op_free_ff;
      want_in       = want_ff;
      cur_in        = cur_ff;
      prev_valid_in = prev_valid_ff;
      prev_in       = prev_ff;
      fidx_in       = fidx_ff;
      found_in      = found_ff;
      at_in         = at_ff;
      scan_in       = scan_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      used_in       = used_ff;
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      end_in        = end_ff;
      rsp_valid_in  = rsp_valid_ff;
      sa_we = 1'b0; sa_waddr = scan_ff; sa_wdata = {carve_addr, want_ff[20:0]};
      nx_we = 1'b0; nx_waddr = prev_ff; nx_wdata = {1'b1, fidx_ff};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_handle_in = 32'd0;
               res_status_in = ST_OK;
               prev_valid_in = 1'b0;
               found_in      = 1'b0;
               cur_in        = head_ff;
               want_in       = {1'b0, req_request_size} + 22'd64;
               want_in[5:0]  = 6'd0;
               op_free_in    = (req_mode == MODE_FREE);
               fidx_in       = hin_id[IW-1:0];
               case (req_mode)
                  MODE_ALLOC: begin
                     if (req_request_size == 21'd0) res_status_in = ST_ZERO_SIZE;
                  end
                  MODE_FREE: begin
                     if (req_handle_in == 32'd0 || id_bad || !used_ff[hin_id[IW-1:0]]) begin
                        res_status_in = ST_FREE_IGN;
                     end else begin
                        cur_in = hin_id[IW-1:0];
                     end
                  end
                  MODE_FREE_ALL: begin
                     used_in       = '0;
                     head_valid_in = 1'b0;
                     end_in        = base_ff;
                  end
                  default: ;
               endcase
            end
         end
         S_FREE_SIZE: begin
            want_in = {1'b0, rd_size};
            cur_in  = head_ff;
            // drop a free of a block that is already listed
            if (rd_listed) res_status_in = ST_FREE_IGN;
         end
         S_WALK_CHK: begin
            if ({1'b0, rd_size} >= want_ff) begin
               found_in = 1'b1;
               at_in    = cur_ff;
               if (!op_free_ff) begin
                  // unlink the hit block
                  if (rd_next == cur_ff) begin
                     if (prev_valid_ff) begin
                        nx_we = 1'b1; nx_wdata = {1'b1, prev_ff};
                     end else begin
                        head_valid_in = 1'b0;
                     end
                  end else begin
                     if (prev_valid_ff) begin
                        nx_we = 1'b1; nx_wdata = {1'b1, rd_next};
                     end else begin
                        head_valid_in = 1'b1; head_in = rd_next;
                     end
                  end
                  fidx_in       = cur_ff;
                  res_handle_in = {8'(cur_ff), 3'd0, rd_addr};
               end
            end else begin
               prev_valid_in = 1'b1;
               prev_in       = cur_ff;
               cur_in        = rd_next;
            end
            scan_in = '0;
         end
         S_ROOM: begin
            scan_in = '0;
            if ({1'b0, want_ff} + 23'd128 > {2'b0, room}) res_status_in = ST_NO_ROOM;
         end
         S_SCAN: begin
            if (!used_ff[scan_ff]) begin
               sa_we = 1'b1;
               nx_we = 1'b1; nx_waddr = scan_ff; nx_wdata = {1'b0, scan_ff};
               used_in[scan_ff] = 1'b1;
               end_in        = carve_addr + want_ff[20:0];
               res_handle_in = {8'(scan_ff), 3'd0, carve_addr};
            end else if (scan_ff == LAST) begin
               res_status_in = ST_NO_DESC;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_PLACE: begin
            // hook the freed block behind its predecessor, or make it the head
            if (prev_valid_ff) begin
               nx_we = 1'b1;
            end else begin
               head_valid_in = 1'b1; head_in = fidx_ff;
            end
         end
         S_LINK: begin
            // write the block's own link and listed flag
            nx_we = 1'b1; nx_waddr = fidx_ff;
            nx_wdata = op_free_ff ? {1'b1, found_ff ? at_ff : fidx_ff} : {1'b0, fidx_ff};
         end
         S_DONE: begin
            if (rsp_load) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // table memories: one write, one registered read at cur_ff
   always_ff @(posedge clock) begin
      if (sa_we) sa_mem[sa_waddr] <= sa_wdata;
      if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
      rd_sa_ff <= sa_mem[cur_ff];
      rd_nx_ff <= nx_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         head_valid_ff <= 1'b0;
         end_ff        <= BASE_RESET;
         base_ff       <= BASE_RESET;
         limit_ff      <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         head_valid_ff <= head_valid_in;
         end_ff        <= end_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (psel && penable && pwrite) begin
            if (paddr[2] == REG_BASE) base_ff <= pwdata[20:0];
            else limit_ff <= pwdata[20:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_free_ff    <= op_free_in;
      want_ff       <= want_in;
      cur_ff        <= cur_in;
      prev_valid_ff <= prev_valid_in;
      prev_ff       <= prev_in;
      fidx_ff       <= fidx_in;
      found_ff      <= found_in;
      at_ff         <= at_in;
      scan_ff       <= scan_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      head_ff       <= head_in;
      if (rsp_load) begin
         rsp_handle_ff <= res_handle_ff;
         rsp_status_ff <= res_status_ff;
      end
   end
endmodule
`default_nettype wire

### rtl/bfla_checker.sv
// ----------------------------------------------------------------------------
// bfla_checker
// Port-level checks of the allocator result channel and register port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_free_list_allocator_core_macros.svh"
module bfla_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_handle_out,
   input wire logic [2:0]  rsp_status,
   input wire logic        pready
);
   import bfla_pkg::*;

   logic        failed;
   logic        rsp_stall;
   logic [34:0] rsp_word;

   assign failed    = rsp_valid && (rsp_status != ST_OK);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_handle_out, rsp_status};

   `BFLA_ASSERT(a_fail_zero, failed |-> rsp_handle_out == '0, "failed word has a handle")
   `BFLA_ASSERT(a_handle_gap, rsp_valid |-> rsp_handle_out[23:21] == '0, "handle gap bits set")
   `BFLA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "held word changed")
   `BFLA_ASSERT_ALWAYS(a_pready, pready, "pready dropped")
endmodule

bind best_fit_free_list_allocator_core bfla_checker u_bfla_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_handle_out(rsp_handle_out), .rsp_status(rsp_status), .pready(pready)
);
`default_nettype wire

### tb/best_fit_free_list_allocator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_core_checker
// Watches the request and response channels and the register port, keeps a
// shadow of the descriptor table and free list, and compares every response.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_core_checker
   import bfla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [20:0] req_request_size,
   input  logic [31:0] req_handle_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_handle_out,
   input  logic [2:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          errors,
   output int          pending
);
   typedef struct packed {
      logic [31:0] handle;
      logic [2:0]  status;
   } alloc_result_type;

   localparam int NDESC = DESCRIPTORS_DEF;

   logic [20:0] blk_addr [NDESC];
   logic [20:0] blk_size [NDESC];
   logic [7:0]  blk_next [NDESC];
   logic        blk_used [NDESC];
   logic        blk_listed [NDESC];
   logic        head_valid;
   logic [7:0]  head_idx;
   logic [20:0] end_ptr;
   logic [20:0] base_reg;
   logic [20:0] limit_reg;
   alloc_result_type expected_results[$];

   assign pending = expected_results.size();

   function automatic void clear_table();
      for (int i = 0; i < NDESC; i++) begin
         blk_addr[i] = '0;
         blk_size[i] = '0;
         blk_next[i] = '0;
         blk_used[i] = 1'b0;
         blk_listed[i] = 1'b0;
      end
      head_valid = 1'b0;
      head_idx = '0;
   endfunction

   // first listed block of size >= want; prev is -1 with no predecessor
   function automatic int find_fit(logic [20:0] want, output int prev);
      int cur;
      int nxt;
      prev = -1;
      cur = head_valid ? int'(head_idx) : -1;
      for (int s = 0; cur >= 0 && s < NDESC; s++) begin
         if (blk_size[cur] >= want) return cur;
         prev = cur;
         nxt = int'(blk_next[cur]);
         cur = (nxt == cur) ? -1 : nxt;
      end
      return -1;
   endfunction

   function automatic alloc_result_type predict_word(logic [1:0] mode, logic [20:0] req,
                                                     logic [31:0] hin);
      alloc_result_type r;
      logic [21:0] rsize;
      logic [21:0] room;
      logic [20:0] addr;
      int prev;
      int blk;
      int d;
      r.handle = '0;
      r.status = ST_OK;
      if (mode == MODE_ALLOC) begin
         if (req == 0) begin
            r.status = ST_ZERO_SIZE;
         end else begin
            rsize = ({1'b0, req} + 22'd64) & ~22'd63;
            blk = (rsize > 22'h1FFFFF) ? -1 : find_fit(rsize[20:0], prev);
            if (rsize > 22'h1FFFFF) prev = -1;
            if (blk >= 0) begin
               if (int'(blk_next[blk]) == blk) begin
                  if (prev >= 0) blk_next[prev] = 8'(prev);
                  else head_valid = 1'b0;
               end else begin
                  if (prev >= 0) blk_next[prev] = blk_next[blk];
                  else begin
                     head_valid = 1'b1;
                     head_idx = blk_next[blk];
                  end
               end
               blk_listed[blk] = 1'b0;
               r.handle = {8'(blk), 3'b0, blk_addr[blk]};
            end else begin
               room = (limit_reg >= end_ptr) ? 22'(limit_reg - end_ptr) : '0;
               if (rsize + 22'd128 > room) begin
                  r.status = ST_NO_ROOM;
               end else begin
                  d = NDESC;
                  for (int i = NDESC - 1; i >= 0; i--) if (!blk_used[i]) d = i;
                  if (d >= NDESC) begin
                     r.status = ST_NO_DESC;
                  end else begin
                     addr = (end_ptr & ~21'd127) + 21'd128;
                     blk_used[d] = 1'b1;
                     blk_listed[d] = 1'b0;
                     blk_addr[d] = addr;
                     blk_size[d] = rsize[20:0];
                     blk_next[d] = 8'(d);
                     end_ptr = addr + rsize[20:0];
                     r.handle = {8'(d), 3'b0, addr};
                  end
               end
            end
         end
      end else if (mode == MODE_FREE) begin
         d = int'(hin[31:24]);
         if (hin == 0 || !blk_used[d] || blk_listed[d]) begin
            r.status = ST_FREE_IGN;
         end else begin
            blk = find_fit(blk_size[d], prev);
            blk_next[d] = 8'(blk >= 0 ? blk : d);
            if (prev >= 0) blk_next[prev] = 8'(d);
            else begin
               head_valid = 1'b1;
               head_idx = 8'(d);
            end
            blk_listed[d] = 1'b1;
         end
      end else if (mode == MODE_FREE_ALL) begin
         clear_table();
         end_ptr = base_reg;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type e;
      if (reset) begin
         clear_table();
         base_reg = BASE_RESET;
         limit_reg = LIMIT_RESET;
         end_ptr = BASE_RESET;
         expected_results.delete();
         errors = 0;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr[2] == REG_BASE) base_reg = pwdata[20:0];
            else limit_reg = pwdata[20:0];
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_word(req_mode, req_request_size,
                                                    req_handle_in));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response word %h/%0d",
                                          rsp_handle_out, rsp_status);
            end else begin
               e = expected_results.pop_front();
               if (e.handle !== rsp_handle_out || e.status !== rsp_status) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: handle exp %h got %h, status exp %0d got %0d",
                              e.handle, rsp_handle_out, e.status, rsp_status);
               end
            end
         end
      end
   end
endmodule

### tb/tb_best_fit_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_free_list_allocator_core
// Drives directed and random allocate / free / free-everything words under
// random gaps and back-pressure, reprograms the area registers between phases
// and lets the checker compare every response against its shadow model.
// ----------------------------------------------------------------------------
module tb_best_fit_free_list_allocator_core;
   import bfla_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [20:0] req_request_size;
   logic [31:0] req_handle_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_handle_out;
   logic [2:0]  rsp_status;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          errors;
   int          pending;
   bit          quiet;        // no idling on either side in the last part
   logic [31:0] live_handles[$];

   best_fit_free_list_allocator_core dut (.*);

   best_fit_free_list_allocator_core_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous: ~1100 words plus stalls
   initial begin
      #10000000;
      $display("tb_best_fit_free_list_allocator_core: done, errors");
      $finish;
   end

   // Remember handles that the block hands out so that frees hit real blocks.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_handle_out != 0)
         live_handles.push_back(rsp_handle_out);

   // Response side: stall in random bursts, none during the quiet tail.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
      end
   end

   task automatic csr_write(logic reg_sel, logic [20:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= {11'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Hold one word on the request channel until accepted; maybe idle before.
   // Valid stays high after acceptance until the next idle or drain.
   task automatic send_word(logic [1:0] mode, logic [20:0] size, logic [31:0] hin);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 13);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_request_size <= size;
      req_handle_in <= hin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, drain all outstanding responses, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [20:0] rand_size();
      case ($urandom_range(0, 9))
         0:       return 21'($urandom);
         1:       return 21'h1FFFFF - 21'($urandom_range(0, 200));
         default: return 21'($urandom_range(1, 4000));
      endcase
   endfunction

   task automatic random_phase(int count);
      int k;
      int pick;
      logic [31:0] h;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_word(MODE_ALLOC, rand_size(), 32'($urandom));
         end else if (pick < 85 && live_handles.size() != 0) begin
            // free a real handle; sometimes twice to hit the double-free path
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            if ($urandom_range(0, 3) != 0) live_handles.delete(k);
            send_word(MODE_FREE, 21'($urandom), h);
         end else if (pick < 93) begin
            send_word(MODE_FREE, 21'($urandom), $urandom);
         end else if (pick < 96) begin
            send_word(2'($urandom_range(2, 3)), 21'($urandom), $urandom);
            // free-all may invalidate handles; forget them after it lands
            drain();
            live_handles.delete();
         end else begin
            send_word(MODE_ALLOC, 21'd0, $urandom);
         end
      end
   endtask

   initial begin
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_ALLOC;
      req_request_size = '0;
      req_handle_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, extremes, reuse, double free, bad frees, modes.
      send_word(MODE_ALLOC, 21'd0, 32'hFFFFFFFF);
      send_word(MODE_ALLOC, 21'd1, '0);
      send_word(MODE_ALLOC, 21'd63, '0);
      send_word(MODE_ALLOC, 21'd64, '0);
      send_word(MODE_ALLOC, 21'h1FFFFF, '0);
      send_word(MODE_ALLOC, 21'd500, '0);
      drain();
      send_word(MODE_FREE, '0, live_handles[1]);
      send_word(MODE_FREE, '0, live_handles[1]);
      send_word(MODE_FREE, '0, live_handles[0]);
      send_word(MODE_FREE, '0, live_handles[2]);
      send_word(MODE_ALLOC, 21'd100, '0);
      send_word(MODE_ALLOC, 21'd10, '0);
      send_word(MODE_ALLOC, 21'd3000, '0);
      send_word(MODE_FREE, '0, 32'h0);
      send_word(MODE_FREE, '0, 32'hFF000000);
      send_word(MODE_FREE, 21'h1FFFFF, 32'h00FFFFFF);
      send_word(2'd3, 21'h1FFFFF, 32'hFFFFFFFF);
      send_word(MODE_FREE_ALL, '0, '0);
      drain();
      live_handles.delete();

      // Tight area: exhaust room, then exhaust descriptors with a wide one.
      csr_write(REG_BASE, 21'd0);
      csr_write(REG_LIMIT, 21'd0);
      send_word(MODE_FREE_ALL, '0, '0);
      send_word(MODE_ALLOC, 21'd1, '0);
      drain();
      csr_write(REG_LIMIT, 21'h1FFFFF);
      for (int i = 0; i < 258; i++) send_word(MODE_ALLOC, 21'd1, '0);
      drain();
      live_handles.delete();
      send_word(MODE_FREE_ALL, '0, '0);
      drain();

      // Random phases over several area settings.
      csr_write(REG_BASE, 21'd20496);
      csr_write(REG_LIMIT, 21'd60000);
      send_word(MODE_FREE_ALL, '0, '0);
      random_phase(300);
      drain();
      csr_write(REG_BASE, 21'h1FFFFF);
      csr_write(REG_LIMIT, 21'd1000);
      send_word(MODE_FREE_ALL, '0, '0);
      random_phase(50);
      drain();
      csr_write(REG_BASE, 21'd4096);
      csr_write(REG_LIMIT, 21'd1867711);
      send_word(MODE_FREE_ALL, '0, '0);
      drain();
      live_handles.delete();
      random_phase(350);
      quiet = 1'b1;
      random_phase(150);
      drain();

      if (errors == 0 && pending == 0)
         $display("tb_best_fit_free_list_allocator_core: done, clean");
      else
         $display("tb_best_fit_free_list_allocator_core: done, errors");
      $finish;
   end
endmodule
